// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the RTL of the allocation map engine.
// Depends on nothing; files that assert include it by its bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Checked property, disabled while rst_n is low.
`define NAM_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("nibble allocation map assertion failed");
// Checked property, also active during reset.
`define NAM_ASSERT_RST(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("nibble allocation map reset assertion failed");
`else
`define NAM_ASSERT(lbl, prop)
`define NAM_ASSERT_RST(lbl, prop)
`endif
`endif

// ===== rtl/core/nam_pkg.sv =====
// Package of the nibble allocation map engine: sizes, entry, status,
// request and register codes. Depends on nothing.
package nam_pkg;
  localparam int HEAP_BYTES = 4096;
  localparam int IDX_W      = $clog2(HEAP_BYTES);
  localparam int LEN_W      = IDX_W + 1;
  localparam int ADDR_W     = 16;
  localparam int CFG_IDX_W  = 1;

  localparam logic [3:0] E_FREE      = 4'd0;
  localparam logic [3:0] E_SH_CLOSED = 4'd8;
  localparam logic [3:0] E_SH_WRITE  = 4'd9;
  localparam logic [3:0] E_SH_READ1  = 4'd10;
  localparam logic [3:0] E_SH_READ4  = 4'd13;
  localparam logic [3:0] E_SH_READ5  = 4'd14;
  localparam logic [3:0] E_CONT      = 4'd15;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_OWNER  = 3'd1;
  localparam logic [2:0] ST_NOTSH  = 3'd2;
  localparam logic [2:0] ST_BUSY   = 3'd3;
  localparam logic [2:0] ST_RANGE  = 3'd4;
  localparam logic [2:0] ST_ROOM   = 3'd5;
  localparam logic [2:0] ST_CLOSED = 3'd6;
  localparam logic [2:0] ST_ZERO   = 3'd7;

  localparam logic [2:0] RQ_CLAIM  = 3'd0;
  localparam logic [2:0] RQ_FREE   = 3'd1;
  localparam logic [2:0] RQ_SIZE   = 3'd2;
  localparam logic [2:0] RQ_RESIZE = 3'd3;
  localparam logic [2:0] RQ_SHFREE = 3'd4;
  localparam logic [2:0] RQ_ROPEN  = 3'd5;
  localparam logic [2:0] RQ_WOPEN  = 3'd6;
  localparam logic [2:0] RQ_CLOSE  = 3'd7;

  localparam logic [3:0] WHO_SHARED = 4'd8;

  localparam logic [CFG_IDX_W-1:0] REG_USE_BASE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USE_LENGTH = 1'd1;

  typedef logic [LEN_W-1:0] len_t;
endpackage

// ===== rtl/core/nam_req_if.sv =====
// Request channel of the allocation map engine.
// Depends on nam_pkg.
interface nam_req_if;
  import nam_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        req_type;
  logic [ADDR_W-1:0] byte_addr;
  len_t              byte_count;
  logic [3:0]        requester;
  modport source (output valid, req_type, byte_addr, byte_count, requester, input ready);
  modport sink (input valid, req_type, byte_addr, byte_count, requester, output ready);
endinterface

// ===== rtl/core/nam_rsp_if.sv =====
// Result channel of the allocation map engine.
// Depends on nam_pkg.
interface nam_rsp_if;
  import nam_pkg::*;
  logic              valid;
  logic              ready;
  logic [2:0]        status;
  logic [ADDR_W-1:0] chunk_start;
  len_t              chunk_length;
  modport source (output valid, status, chunk_start, chunk_length, input ready);
  modport sink (input valid, status, chunk_start, chunk_length, output ready);
endinterface

// ===== rtl/core/nam_cfg_if.sv =====
// Configuration write channel of the allocation map engine.
// Depends on nam_pkg.
interface nam_cfg_if;
  import nam_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [15:0]          data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== rtl/core/nibble_allocation_map_engine.sv =====
// Top level of the nibble allocation map engine: map memory and sequencer.
// Depends on nam_pkg, the three channel interfaces and assert_macros.svh.
//
//  Channel  Modport  Moves per transfer
//  in_ch    sink     req_type, byte_addr, byte_count, requester
//  out_ch   source   status, chunk_start, chunk_length
//  cfg_ch   sink     index, data (always ready)
//
// After rst_n is released a clearing pass writes every map entry to free,
// one entry a cycle; no request is taken then.
// A request passes accept, decode and result states, plus an operate state when
// it finds a chunk, plus a read state and a check state per map entry it reads
// (one memory read port with registered data), plus a write per entry it writes
// and a closing step to end any write sweep.
// The input is not ready from acceptance until the result transfer completes;
// a stalled result simply holds in the output registers.
`include "assert_macros.svh"
module nibble_allocation_map_engine (
  input  logic      clk,
  input  logic      rst_n,
  nam_req_if.sink   in_ch,
  nam_rsp_if.source out_ch,
  nam_cfg_if.sink   cfg_ch
);
  import nam_pkg::*;

  localparam logic [3:0] S_CLR     = 4'd0;
  localparam logic [3:0] S_IDLE    = 4'd1;
  localparam logic [3:0] S_START   = 4'd2;
  localparam logic [3:0] S_LOOK_RD = 4'd3;
  localparam logic [3:0] S_LOOK_CK = 4'd4;
  localparam logic [3:0] S_FWD_RD  = 4'd5;
  localparam logic [3:0] S_FWD_CK  = 4'd6;
  localparam logic [3:0] S_OP      = 4'd7;
  localparam logic [3:0] S_SCAN_RD = 4'd8;
  localparam logic [3:0] S_SCAN_CK = 4'd9;
  localparam logic [3:0] S_HEAD    = 4'd10;
  localparam logic [3:0] S_SWEEP   = 4'd11;
  localparam logic [3:0] S_OUT     = 4'd12;

  localparam len_t LAST_IDX = len_t'(HEAP_BYTES - 1);
  localparam len_t HEAP_LEN = len_t'(HEAP_BYTES);

  // Configuration registers.
  logic [ADDR_W-1:0] base_r;
  len_t              ulen_r;
  len_t              rlen;

  // Sequencer state and request context.
  logic [3:0]        state_r, state_nxt;
  logic [2:0]        req_r, req_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  len_t              cnt_r, cnt_nxt;
  logic [3:0]        who_r, who_nxt;
  len_t              idx_r, idx_nxt;
  len_t              first_r, first_nxt;
  len_t              len_r, len_nxt;
  logic [3:0]        e_r, e_nxt;
  len_t              ptr_r, ptr_nxt;
  len_t              end_r, end_nxt;
  logic [3:0]        wval_r, wval_nxt;
  logic              look_first_r, look_first_nxt;

  // Result registers.
  logic [2:0]        status_r, status_nxt;
  logic [ADDR_W-1:0] start_r, start_nxt;
  len_t              olen_r, olen_nxt;

  // Map memory, one read and one write port.
  logic [3:0]        map_mem [HEAP_BYTES];
  logic [3:0]        rd_r;
  logic              we;
  logic [IDX_W-1:0]  waddr;
  logic [3:0]        wdata;

  logic [ADDR_W-1:0] off;
  logic              inrange;
  len_t              ptr_inc;
  logic [LEN_W:0]    grow_end;

  assign rlen = (ulen_r > HEAP_LEN) ? HEAP_LEN : ulen_r;

  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
      ulen_r <= HEAP_LEN;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_USE_BASE:   base_r <= cfg_ch.data;
        REG_USE_LENGTH: ulen_r <= cfg_ch.data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = (state_r == S_OUT);
  assign out_ch.status       = status_r;
  assign out_ch.chunk_start  = start_r;
  assign out_ch.chunk_length = olen_r;

  assign off      = addr_r - base_r;
  assign inrange  = (addr_r >= base_r) && (off < ADDR_W'(rlen));
  assign ptr_inc  = ptr_r + 1'b1;
  assign grow_end = {1'b0, first_r} + {1'b0, cnt_r};

  // The map is read every cycle at the pointer; the data is registered, valid in the next cycle.
  always_ff @(posedge clk) begin
    rd_r <= map_mem[ptr_r[IDX_W-1:0]];
    if (we) begin
      map_mem[waddr] <= wdata;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = ptr_r[IDX_W-1:0];
    wdata = wval_r;
    unique case (state_r)
      S_CLR: begin
        we    = 1'b1;
        wdata = E_FREE;
      end
      S_HEAD: begin
        we    = 1'b1;
        waddr = idx_r[IDX_W-1:0];
        wdata = who_r;
      end
      S_SWEEP: we = (ptr_r < end_r);
      default: ;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    req_nxt        = req_r;
    addr_nxt       = addr_r;
    cnt_nxt        = cnt_r;
    who_nxt        = who_r;
    idx_nxt        = idx_r;
    first_nxt      = first_r;
    len_nxt        = len_r;
    e_nxt          = e_r;
    ptr_nxt        = ptr_r;
    end_nxt        = end_r;
    wval_nxt       = wval_r;
    look_first_nxt = look_first_r;
    status_nxt     = status_r;
    start_nxt      = start_r;
    olen_nxt       = olen_r;
    unique case (state_r)
      S_CLR: begin
        ptr_nxt = ptr_inc;
        if (ptr_r == LAST_IDX) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_ch.valid) begin
          req_nxt   = in_ch.req_type;
          addr_nxt  = in_ch.byte_addr;
          cnt_nxt   = in_ch.byte_count;
          who_nxt   = in_ch.requester;
          state_nxt = S_START;
        end
      end
      S_START: begin
        idx_nxt    = off[LEN_W-1:0];
        ptr_nxt    = off[LEN_W-1:0];
        status_nxt = ST_OK;
        start_nxt  = addr_r;
        olen_nxt   = '0;
        if (!inrange) begin
          status_nxt = ST_RANGE;
          state_nxt  = S_OUT;
        end else if (req_r == RQ_CLAIM) begin
          end_nxt = off[LEN_W-1:0] + cnt_r;
          if (who_r == E_FREE || who_r > WHO_SHARED) begin
            status_nxt = ST_OWNER;
            state_nxt  = S_OUT;
          end else if (cnt_r == '0) begin
            status_nxt = ST_ZERO;
            state_nxt  = S_OUT;
          end else if (cnt_r > rlen - off[LEN_W-1:0]) begin
            status_nxt = ST_ROOM;
            state_nxt  = S_OUT;
          end else begin
            state_nxt = S_SCAN_RD;
          end
        end else begin
          look_first_nxt = 1'b1;
          state_nxt      = S_LOOK_RD;
        end
      end
      S_LOOK_RD: state_nxt = S_LOOK_CK;
      S_LOOK_CK: begin
        look_first_nxt = 1'b0;
        if (look_first_r && rd_r == E_FREE) begin
          state_nxt = S_OUT;
          case (req_r)
            RQ_FREE:   status_nxt = (who_r == E_FREE) ? ST_OK : ST_OWNER;
            RQ_SIZE:   status_nxt = ST_OK;
            RQ_RESIZE: status_nxt = ST_OWNER;
            default:   status_nxt = ST_NOTSH;
          endcase
        end else if (rd_r == E_CONT && ptr_r != '0) begin
          // Walk back toward the head of the chunk.
          ptr_nxt   = ptr_r - 1'b1;
          state_nxt = S_LOOK_RD;
        end else begin
          e_nxt     = rd_r;
          first_nxt = ptr_r;
          len_nxt   = len_t'(1);
          ptr_nxt   = ptr_inc;
          state_nxt = (ptr_inc < rlen) ? S_FWD_RD : S_OP;
        end
      end
      S_FWD_RD: state_nxt = S_FWD_CK;
      S_FWD_CK: begin
        if (rd_r == E_CONT) begin
          len_nxt   = len_r + 1'b1;
          ptr_nxt   = ptr_inc;
          state_nxt = (ptr_inc < rlen) ? S_FWD_RD : S_OP;
        end else begin
          state_nxt = S_OP;
        end
      end
      S_OP: begin
        start_nxt = base_r + ADDR_W'(first_r);
        olen_nxt  = len_r;
        state_nxt = S_OUT;
        ptr_nxt   = first_r;
        end_nxt   = first_r + 1'b1;
        case (req_r)
          RQ_FREE: begin
            if (e_r != who_r) begin
              status_nxt = ST_OWNER;
            end else begin
              end_nxt   = first_r + len_r;
              wval_nxt  = E_FREE;
              state_nxt = S_SWEEP;
            end
          end
          RQ_RESIZE: begin
            if (e_r != who_r) begin
              status_nxt = ST_OWNER;
            end else if (cnt_r == '0) begin
              status_nxt = ST_ZERO;
            end else if (cnt_r > len_r) begin
              // Growth must stay in the region and find only free bytes.
              if (grow_end > {1'b0, rlen}) begin
                status_nxt = ST_ROOM;
              end else begin
                ptr_nxt   = first_r + len_r;
                end_nxt   = grow_end[LEN_W-1:0];
                state_nxt = S_SCAN_RD;
              end
            end else begin
              ptr_nxt   = first_r + cnt_r;
              end_nxt   = first_r + len_r;
              wval_nxt  = E_FREE;
              olen_nxt  = cnt_r;
              state_nxt = S_SWEEP;
            end
          end
          RQ_SHFREE: begin
            if (e_r == E_SH_CLOSED) begin
              end_nxt   = first_r + len_r;
              wval_nxt  = E_FREE;
              state_nxt = S_SWEEP;
            end else if (e_r >= E_SH_WRITE && e_r <= E_SH_READ5) begin
              status_nxt = ST_BUSY;
            end else begin
              status_nxt = ST_NOTSH;
            end
          end
          RQ_ROPEN: begin
            if (e_r == E_SH_CLOSED) begin
              wval_nxt  = E_SH_READ1;
              state_nxt = S_SWEEP;
            end else if (e_r >= E_SH_READ1 && e_r <= E_SH_READ4) begin
              wval_nxt  = e_r + 1'b1;
              state_nxt = S_SWEEP;
            end else if (e_r == E_SH_WRITE || e_r == E_SH_READ5) begin
              status_nxt = ST_BUSY;
            end else begin
              status_nxt = ST_NOTSH;
            end
          end
          RQ_WOPEN: begin
            if (e_r == E_SH_CLOSED) begin
              wval_nxt  = E_SH_WRITE;
              state_nxt = S_SWEEP;
            end else if (e_r >= E_SH_WRITE && e_r <= E_SH_READ5) begin
              status_nxt = ST_BUSY;
            end else begin
              status_nxt = ST_NOTSH;
            end
          end
          RQ_CLOSE: begin
            if (e_r == E_SH_WRITE || e_r == E_SH_READ1) begin
              wval_nxt  = E_SH_CLOSED;
              state_nxt = S_SWEEP;
            end else if (e_r > E_SH_READ1 && e_r <= E_SH_READ5) begin
              wval_nxt  = e_r - 1'b1;
              state_nxt = S_SWEEP;
            end else if (e_r == E_SH_CLOSED) begin
              status_nxt = ST_CLOSED;
            end else begin
              status_nxt = ST_NOTSH;
            end
          end
          default: ;
        endcase
      end
      S_SCAN_RD: state_nxt = S_SCAN_CK;
      S_SCAN_CK: begin
        // Every byte of the range must be free for a claim or a growth.
        if (rd_r != E_FREE) begin
          status_nxt = ST_ROOM;
          state_nxt  = S_OUT;
        end else if (ptr_inc == end_r) begin
          olen_nxt = cnt_r;
          wval_nxt = E_CONT;
          if (req_r == RQ_CLAIM) begin
            state_nxt = S_HEAD;
          end else begin
            ptr_nxt   = first_r + len_r;
            state_nxt = S_SWEEP;
          end
        end else begin
          ptr_nxt   = ptr_inc;
          state_nxt = S_SCAN_RD;
        end
      end
      S_HEAD: begin
        ptr_nxt   = idx_r + 1'b1;
        state_nxt = S_SWEEP;
      end
      S_SWEEP: begin
        if (ptr_r < end_r) begin
          ptr_nxt = ptr_inc;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ch.ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLR;
      ptr_r        <= '0;
      look_first_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      ptr_r        <= ptr_nxt;
      look_first_r <= look_first_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    addr_r   <= addr_nxt;
    cnt_r    <= cnt_nxt;
    who_r    <= who_nxt;
    idx_r    <= idx_nxt;
    first_r  <= first_nxt;
    len_r    <= len_nxt;
    e_r      <= e_nxt;
    end_r    <= end_nxt;
    wval_r   <= wval_nxt;
    status_r <= status_nxt;
    start_r  <= start_nxt;
    olen_r   <= olen_nxt;
  end

  `NAM_ASSERT_RST(a_reset_clears, !rst_n |=> state_r == S_CLR)
  `NAM_ASSERT(a_one_at_a_time, !(in_ch.ready && out_ch.valid))
  `NAM_ASSERT(a_busy_after_take, in_ch.valid && in_ch.ready |=> !in_ch.ready)
  `NAM_ASSERT(a_write_in_region, we && state_r != S_CLR |-> len_t'(waddr) < rlen)
endmodule
